>>> src/chip8_instruction_execute_macros.svh
// assertion macros for the chip8 execute unit
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
// concurrent assertion under clock and reset
`define C8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication whose consequent is checked in the next cycle
`define C8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/c8ex_pkg.sv
// shared types, constants and tables for the chip8 execute unit
`timescale 1ns / 1ps
`default_nettype none
package c8ex_pkg;
    localparam int MEMORY_BYTES_DEF  = 4096;
    localparam int PROGRAM_START_DEF = 512;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int GLYPH_HEIGHT      = 5;
    localparam int FONT_BYTES        = 80;
    localparam int ADDR_W            = 12;

    localparam logic [1:0] DISP_NONE  = 2'd0;
    localparam logic [1:0] DISP_CLEAR = 2'd1;
    localparam logic [1:0] DISP_DRAW  = 2'd2;
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_FULL = 2'd1;
    localparam logic [1:0] FAULT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_MEMRD,
        ST_MEMWAIT,
        ST_LOADREG,
        ST_STORE,
        ST_BCD,
        ST_POP,
        ST_POPWAIT,
        ST_DONE
    } state_t;

    // command from controller to datapath
    typedef struct packed {
        logic              capture;
        logic              init_wr;
        logic [ADDR_W-1:0] init_addr;
        logic              exec;
        logic              load_wr;
        logic              mem_rd;
        logic              load_reg;
        logic              store_wr;
        logic              bcd_wr;
        logic              pop;
        logic              publish;
        logic [3:0]        step;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic       action;
        logic       is_ld;
        logic       is_st;
        logic       is_bcd;
        logic       is_ret;
        logic [3:0] x;
    } stat_t;

    function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
        logic [7:0] f [0:79];
        f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (a < ADDR_W'(FONT_BYTES))
            font_byte = f[a[6:0]];
        else
            font_byte = 8'h00;
    endfunction
endpackage
`default_nettype wire

>>> src/c8ex_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module c8ex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/c8ex_ctrl.sv
// controller state machine of the chip8 execute unit
`timescale 1ns / 1ps
`default_nettype none
`include "chip8_instruction_execute_macros.svh"
module c8ex_ctrl #(
    parameter int MEMORY_BYTES = c8ex_pkg::MEMORY_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire c8ex_pkg::stat_t st,
    output c8ex_pkg::ctrl_t     ctl
);
    import c8ex_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] init_reg, init_next;
    logic [3:0]        step_reg, step_next;
    logic              ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            init_reg  <= '0;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        step_next  = step_reg;
        ov_next    = ov_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                init_next = init_reg + ADDR_W'(1);
                if (init_reg == ADDR_W'(MEMORY_BYTES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
            begin
                step_next = '0;
                if (!st.action)
                    state_next = ST_DONE;
                else if (st.is_ld)
                    state_next = ST_MEMRD;
                else if (st.is_st)
                    state_next = ST_STORE;
                else if (st.is_bcd)
                    state_next = ST_BCD;
                else if (st.is_ret)
                    state_next = ST_POP;
                else
                    state_next = ST_DONE;
            end
            ST_MEMRD:
                state_next = ST_MEMWAIT;
            ST_MEMWAIT:
                state_next = ST_LOADREG;
            ST_LOADREG:
            begin
                step_next = step_reg + 4'd1;
                state_next = (step_reg == st.x) ? ST_DONE : ST_MEMRD;
            end
            ST_STORE:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == st.x)
                    state_next = ST_DONE;
            end
            ST_BCD:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd2)
                    state_next = ST_DONE;
            end
            ST_POP:
                state_next = ST_POPWAIT;
            ST_POPWAIT:
                state_next = ST_DONE;
            ST_DONE:
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.step = step_reg;
        ctl.init_addr = init_reg;
        case (state_reg)
            ST_INIT:    ctl.init_wr = 1'b1;
            ST_IDLE:    ctl.capture = in_valid;
            ST_DECODE:
            begin
                ctl.exec    = st.action && !st.is_ld && !st.is_st && !st.is_bcd;
                ctl.load_wr = !st.action;
            end
            ST_MEMRD:   ctl.mem_rd = 1'b1;
            ST_LOADREG: ctl.load_reg = 1'b1;
            ST_STORE:   ctl.store_wr = 1'b1;
            ST_BCD:     ctl.bcd_wr = 1'b1;
            ST_POP:     ctl.pop = 1'b1;
            ST_DONE:    ctl.publish = !ov_reg || !out_stall;
            default:    ;
        endcase
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = ov_reg;

    `C8_ASSERT_NEXT(a_one_beat, state_reg == ST_DONE, out_valid,
        "result not presented after done")
    `C8_ASSERT(a_no_accept_busy, (state_reg != ST_IDLE) |-> in_stall,
        "input accepted while busy")
    `C8_ASSERT_NEXT(a_bcd_len, state_reg == ST_BCD && step_reg == 4'd2,
        state_reg == ST_DONE, "bcd ran past three bytes")
endmodule
`default_nettype wire

>>> src/c8ex_dpath.sv
// datapath of the chip8 execute unit: registers, stack, memory and alu
`timescale 1ns / 1ps
`default_nettype none
module c8ex_dpath #(
    parameter int MEMORY_BYTES  = c8ex_pkg::MEMORY_BYTES_DEF,
    parameter int PROGRAM_START = c8ex_pkg::PROGRAM_START_DEF,
    parameter int STACK_DEPTH   = c8ex_pkg::STACK_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire c8ex_pkg::ctrl_t ctl,
    output c8ex_pkg::stat_t      st,
    input  wire logic            action,
    input  wire logic [15:0]     opcode,
    input  wire logic [11:0]     load_address,
    input  wire logic [7:0]      load_data,
    input  wire logic [15:0]     keys_down,
    input  wire logic [3:0]      wait_key,
    input  wire logic [7:0]      random_value,
    output logic [11:0]          program_counter,
    output logic [15:0]          index_register,
    output logic [7:0]           flag_register,
    output logic [7:0]           delay_count,
    output logic [7:0]           sound_count,
    output logic [1:0]           display_request,
    output logic [7:0]           draw_x,
    output logic [7:0]           draw_y,
    output logic [3:0]           draw_rows,
    output logic [1:0]           stack_fault
);
    import c8ex_pkg::*;
    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int SI = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic        act_reg;
    logic [15:0] op_reg;
    logic [11:0] la_reg;
    logic [7:0]  ld_reg, rnd_reg;
    logic [15:0] keys_reg;
    logic [3:0]  key_reg;

    logic [7:0]  v_reg [0:15];
    logic [15:0] i_reg;
    logic [11:0] pc_reg;
    logic [SW-1:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [1:0]  disp_reg, fault_reg;
    logic [7:0]  dx_reg, dy_reg;
    logic [3:0]  dn_reg;

    logic [11:0] pc_o_reg;
    logic [15:0] i_o_reg;
    logic [7:0]  vf_o_reg, dt_o_reg, st_o_reg, dx_o_reg, dy_o_reg;
    logic [1:0]  disp_o_reg, fault_o_reg;
    logic [3:0]  dn_o_reg;

    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    assign x = op_reg[11:8];
    assign y = op_reg[7:4];
    assign n = op_reg[3:0];
    assign kk = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];

    logic is_ret, is_call;
    assign is_ret  = op_reg == 16'h00EE;
    assign is_call = op_reg[15:12] == 4'h2;
    assign st.action = act_reg;
    assign st.is_ld  = op_reg[15:12] == 4'hF && kk == 8'h65;
    assign st.is_st  = op_reg[15:12] == 4'hF && kk == 8'h55;
    assign st.is_bcd = op_reg[15:12] == 4'hF && kk == 8'h33;
    assign st.is_ret = is_ret && sp_reg != '0 && sp_reg <= SW'(STACK_DEPTH);
    assign st.x      = x;

    // bcd digits
    logic [7:0] hund, rem1, tens, ones, bcd_byte;
    always_comb
    begin
        hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        rem1 = vx - 8'((hund * 8'd100));
        tens = 8'((16'(rem1) * 16'd205) >> 11);
        ones = rem1 - 8'(tens * 8'd10);
        case (ctl.step[1:0])
            2'd0:    bcd_byte = hund;
            2'd1:    bcd_byte = tens;
            default: bcd_byte = ones;
        endcase
    end

    // memory port
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [7:0]    m_wd, m_rd;
    always_comb
    begin
        m_we = 1'b0;
        m_addr = AW'(i_reg[11:0] + 12'(ctl.step));
        m_wd = v_reg[ctl.step];
        if (ctl.init_wr)
        begin
            m_we = 1'b1;
            m_addr = AW'(ctl.init_addr);
            m_wd = font_byte(ctl.init_addr);
        end
        else if (ctl.load_wr)
        begin
            m_we = 1'b1;
            m_addr = AW'(la_reg);
            m_wd = ld_reg;
        end
        else if (ctl.store_wr)
            m_we = 1'b1;
        else if (ctl.bcd_wr)
        begin
            m_we = 1'b1;
            m_wd = bcd_byte;
        end
    end

    c8ex_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
    );

    // return stack
    logic [11:0] stk_rd;
    logic [SI-1:0] stk_addr;
    assign stk_addr = ctl.pop ? SI'(sp_reg - SW'(1)) : SI'(sp_reg);
    c8ex_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk),
        .we(ctl.exec && is_call && sp_reg < SW'(STACK_DEPTH)),
        .addr(stk_addr), .wdata(pc_reg), .rdata(stk_rd)
    );

    logic held;
    assign held = vx < 8'd16 && keys_reg[vx[3:0]];
    logic [8:0] sum;
    assign sum = {1'b0, vx} + {1'b0, vy};

    // stack read data is valid the cycle after the pop
    logic pop_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop_d_reg <= 1'b0;
        else
            pop_d_reg <= ctl.pop;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            act_reg  <= action;
            op_reg   <= opcode;
            la_reg   <= load_address;
            ld_reg   <= load_data;
            keys_reg <= keys_down;
            key_reg  <= wait_key;
            rnd_reg  <= random_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                v_reg[k] <= '0;
            i_reg <= '0;
            pc_reg <= '0;
            sp_reg <= '0;
            dt_reg <= '0;
            st_reg <= '0;
            disp_reg <= DISP_NONE;
            fault_reg <= FAULT_NONE;
            dx_reg <= '0;
            dy_reg <= '0;
            dn_reg <= '0;
        end
        else
        begin
            if (ctl.capture)
            begin
                disp_reg <= DISP_NONE;
                fault_reg <= FAULT_NONE;
                dx_reg <= '0;
                dy_reg <= '0;
                dn_reg <= '0;
            end
            if (ctl.load_wr)
                pc_reg <= 12'(PROGRAM_START);
            if (ctl.load_reg)
                v_reg[ctl.step] <= m_rd;
            if (ctl.pop)
                sp_reg <= sp_reg - SW'(1);
            if (pop_d_reg)
                pc_reg <= stk_rd;
            if (ctl.exec)
            begin
                if (op_reg == 16'h00E0)
                    disp_reg <= DISP_CLEAR;
                else if (is_ret)
                begin
                    if (!st.is_ret)
                        fault_reg <= FAULT_EMPTY;
                end
                else
                    case (op_reg[15:12])
                        4'h1: pc_reg <= nnn;
                        4'h2:
                            if (sp_reg >= SW'(STACK_DEPTH))
                                fault_reg <= FAULT_FULL;
                            else
                            begin
                                sp_reg <= sp_reg + SW'(1);
                                pc_reg <= nnn;
                            end
                        4'h3: if (vx == kk) pc_reg <= pc_reg + 12'd2;
                        4'h4: if (vx != kk) pc_reg <= pc_reg + 12'd2;
                        4'h5: if (vx == vy) pc_reg <= pc_reg + 12'd2;
                        4'h6: v_reg[x] <= kk;
                        4'h7: v_reg[x] <= vx + kk;
                        4'h8:
                            case (n)
                                4'h0: v_reg[x] <= vy;
                                4'h1: v_reg[x] <= vx | vy;
                                4'h2: v_reg[x] <= vx & vy;
                                4'h3: v_reg[x] <= vx ^ vy;
                                4'h4:
                                begin
                                    if (x != 4'hF)
                                        v_reg[15] <= {7'd0, sum[8]};
                                    v_reg[x] <= sum[7:0];
                                end
                                4'h5:
                                begin
                                    if (x != 4'hF)
                                        v_reg[15] <= {7'd0, vx > vy};
                                    v_reg[x] <= vx - vy;
                                end
                                4'h6:
                                begin
                                    if (x != 4'hF)
                                        v_reg[15] <= {7'd0, vx[0]};
                                    v_reg[x] <= vx >> 1;
                                end
                                4'h7:
                                begin
                                    if (x != 4'hF)
                                        v_reg[15] <= {7'd0, vy > vx};
                                    v_reg[x] <= vy - vx;
                                end
                                4'hE:
                                begin
                                    if (x != 4'hF)
                                        v_reg[15] <= {7'd0, vx[7]};
                                    v_reg[x] <= vx << 1;
                                end
                                default: v_reg[x] <= vx;
                            endcase
                        4'h9: if (vx != vy) pc_reg <= pc_reg + 12'd2;
                        4'hA: i_reg <= {4'd0, nnn};
                        4'hB: pc_reg <= {4'd0, v_reg[0]} + nnn;
                        4'hC: v_reg[x] <= ((rnd_reg == 8'hFF) ? 8'h00 : rnd_reg) & kk;
                        4'hD:
                        begin
                            disp_reg <= DISP_DRAW;
                            dx_reg <= vx;
                            dy_reg <= vy;
                            dn_reg <= n;
                        end
                        4'hE:
                            if ((kk == 8'h9E && held) || (kk == 8'hA1 && !held))
                                pc_reg <= pc_reg + 12'd2;
                        4'hF:
                            case (kk)
                                8'h07: v_reg[x] <= dt_reg;
                                8'h0A: v_reg[x] <= {4'd0, key_reg};
                                8'h15: dt_reg <= vx;
                                8'h18: st_reg <= vx;
                                8'h1E: i_reg <= i_reg + {8'd0, vx};
                                8'h29: i_reg <= 16'({vx, 2'b00}) + {8'd0, vx};
                                default: i_reg <= i_reg;
                            endcase
                        default: pc_reg <= pc_reg;
                    endcase
            end
        end
    end

    // result register, holds the beat while the next item runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_o_reg <= '0;
            i_o_reg <= '0;
            vf_o_reg <= '0;
            dt_o_reg <= '0;
            st_o_reg <= '0;
            disp_o_reg <= DISP_NONE;
            dx_o_reg <= '0;
            dy_o_reg <= '0;
            dn_o_reg <= '0;
            fault_o_reg <= FAULT_NONE;
        end
        else if (ctl.publish)
        begin
            pc_o_reg <= pc_reg;
            i_o_reg <= i_reg;
            vf_o_reg <= v_reg[15];
            dt_o_reg <= dt_reg;
            st_o_reg <= st_reg;
            disp_o_reg <= disp_reg;
            dx_o_reg <= dx_reg;
            dy_o_reg <= dy_reg;
            dn_o_reg <= dn_reg;
            fault_o_reg <= fault_reg;
        end
    end

    assign program_counter = pc_o_reg;
    assign index_register  = i_o_reg;
    assign flag_register   = vf_o_reg;
    assign delay_count     = dt_o_reg;
    assign sound_count     = st_o_reg;
    assign display_request = disp_o_reg;
    assign draw_x          = dx_o_reg;
    assign draw_y          = dy_o_reg;
    assign draw_rows       = dn_o_reg;
    assign stack_fault     = fault_o_reg;
endmodule
`default_nettype wire

>>> src/chip8_instruction_execute.sv
// top level of the chip8 execute unit
// One beat in gives one beat out and items run one at a time. Simple opcodes,
// program byte writes and an empty-stack return go from decode to done; Fx33
// walks the bcd write state for each of three digits, Fx55 the store state
// for each register up to Vx, Fx65 the read, wait and load states for each
// register through the registered program memory read, and a popping return
// the pop and pop-wait states. out_valid rises as the unit returns to idle,
// ready for the next beat; a result still waiting in the output register only
// holds back the next result, not the next input. After reset a clearing pass
// over all of memory loads the font and zeros the rest before the first beat.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_execute #(
    parameter int MEMORY_BYTES  = c8ex_pkg::MEMORY_BYTES_DEF,
    parameter int PROGRAM_START = c8ex_pkg::PROGRAM_START_DEF,
    parameter int STACK_DEPTH   = c8ex_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [15:0] opcode,
    input  wire logic [11:0] load_address,
    input  wire logic [7:0]  load_data,
    input  wire logic [15:0] keys_down,
    input  wire logic [3:0]  wait_key,
    input  wire logic [7:0]  random_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      program_counter,
    output logic [15:0]      index_register,
    output logic [7:0]       flag_register,
    output logic [7:0]       delay_count,
    output logic [7:0]       sound_count,
    output logic [1:0]       display_request,
    output logic [7:0]       draw_x,
    output logic [7:0]       draw_y,
    output logic [3:0]       draw_rows,
    output logic [1:0]       stack_fault
);
    import c8ex_pkg::*;
    ctrl_t ctl;
    stat_t st;

    c8ex_ctrl #(.MEMORY_BYTES(MEMORY_BYTES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .st(st), .ctl(ctl)
    );

    c8ex_dpath #(
        .MEMORY_BYTES(MEMORY_BYTES), .PROGRAM_START(PROGRAM_START),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dpath (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st),
        .action(action), .opcode(opcode), .load_address(load_address),
        .load_data(load_data), .keys_down(keys_down), .wait_key(wait_key),
        .random_value(random_value),
        .program_counter(program_counter), .index_register(index_register),
        .flag_register(flag_register), .delay_count(delay_count),
        .sound_count(sound_count), .display_request(display_request),
        .draw_x(draw_x), .draw_y(draw_y), .draw_rows(draw_rows),
        .stack_fault(stack_fault)
    );
endmodule
`default_nettype wire

>>> tb/chip8_instruction_execute_tb.sv
// self-checking testbench for the chip8 execute unit
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_execute_tb;
    import c8ex_pkg::*;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] idx;
        logic [7:0]  vf;
        logic [7:0]  dt;
        logic [7:0]  st;
        logic [1:0]  disp;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [3:0]  rows;
        logic [1:0]  fault;
    } machine_view_t;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EXEC = 1'b1;
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0] KK_SKP  = 8'h9E;
    localparam logic [7:0] KK_SKNP = 8'hA1;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [15:0] opcode = '0;
    logic [11:0] load_address = '0;
    logic [7:0] load_data = '0;
    logic [15:0] keys_down = '0;
    logic [3:0] wait_key = '0;
    logic [7:0] random_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [11:0] program_counter;
    logic [15:0] index_register;
    logic [7:0] flag_register, delay_count, sound_count, draw_x, draw_y;
    logic [1:0] display_request, stack_fault;
    logic [3:0] draw_rows;

    logic [7:0] v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg, ret_stack [16];
    int sp;
    logic [7:0] dt_reg, st_reg;
    logic [7:0] ram [4096];

    machine_view_t pending_views[$];
    int errors = 0;
    int cycles = 0;

    chip8_instruction_execute u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receive side with random stall
    int stall_left = 0;
    always @(posedge clk)
    begin
        machine_view_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{program_counter, index_register, flag_register, delay_count,
                    sound_count, display_request, draw_x, draw_y, draw_rows,
                    stack_fault};
            if (pending_views.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat %p", got);
            end
            else
            begin
                want = pending_views.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %p act %p", want, got);
                end
            end
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic machine_reset();
        for (int k = 0; k < 16; k++)
        begin
            v_reg[k] = '0;
            ret_stack[k] = '0;
        end
        for (int k = 0; k < 4096; k++)
            ram[k] = (k < FONT_BYTES) ? font_byte(12'(k)) : 8'h00;
        i_reg = '0; pc_reg = '0; sp = 0; dt_reg = '0; st_reg = '0;
    endtask

    function automatic void skip_when(input logic c);
        if (c)
            pc_reg = pc_reg + 12'd2;
    endfunction

    task automatic execute_model(input logic act, input logic [15:0] op,
                                 input logic [11:0] la, input logic [7:0] ld,
                                 input logic [15:0] keys, input logic [3:0] key,
                                 input logic [7:0] rnd);
        machine_view_t r;
        logic [3:0] x, y, n;
        logic [7:0] kk, a, b;
        logic [8:0] s;
        logic held;
        x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
        a = v_reg[x]; b = v_reg[y];
        r = '0;
        if (act == ACT_LOAD)
        begin
            ram[la] = ld;
            pc_reg = 12'(PROGRAM_START_DEF);
        end
        else if (op == OP_CLS)
            r.disp = DISP_CLEAR;
        else if (op == OP_RET)
        begin
            if (sp == 0)
                r.fault = FAULT_EMPTY;
            else
            begin
                sp--;
                pc_reg = ret_stack[sp];
            end
        end
        else
            case (op[15:12])
                4'h1: pc_reg = op[11:0];
                4'h2:
                    if (sp >= STACK_DEPTH_DEF)
                        r.fault = FAULT_FULL;
                    else
                    begin
                        ret_stack[sp] = pc_reg;
                        sp++;
                        pc_reg = op[11:0];
                    end
                4'h3: skip_when(a == kk);
                4'h4: skip_when(a != kk);
                4'h5: skip_when(a == b);
                4'h6: v_reg[x] = kk;
                4'h7: v_reg[x] = a + kk;
                4'h8:
                    case (n)
                        4'h0: v_reg[x] = b;
                        4'h1: v_reg[x] = a | b;
                        4'h2: v_reg[x] = a & b;
                        4'h3: v_reg[x] = a ^ b;
                        4'h4: begin s = a + b; v_reg[15] = {7'd0, s[8]}; v_reg[x] = s[7:0]; end
                        4'h5: begin v_reg[15] = {7'd0, a > b}; v_reg[x] = a - b; end
                        4'h6: begin v_reg[15] = {7'd0, a[0]}; v_reg[x] = a >> 1; end
                        4'h7: begin v_reg[15] = {7'd0, b > a}; v_reg[x] = b - a; end
                        4'hE: begin v_reg[15] = {7'd0, a[7]}; v_reg[x] = a << 1; end
                        default: ;
                    endcase
                4'h9: skip_when(a != b);
                4'hA: i_reg = {4'd0, op[11:0]};
                4'hB: pc_reg = 12'(v_reg[0]) + op[11:0];
                4'hC: v_reg[x] = 8'((rnd % 255) & kk);
                4'hD:
                begin
                    r.disp = DISP_DRAW; r.dx = a; r.dy = b; r.rows = n;
                end
                4'hE:
                begin
                    held = keys[a[3:0]] && (a < 16);
                    if (kk == KK_SKP) skip_when(held);
                    else if (kk == KK_SKNP) skip_when(!held);
                end
                4'hF:
                    case (kk)
                        8'h07: v_reg[x] = dt_reg;
                        8'h0A: v_reg[x] = {4'd0, key};
                        8'h15: dt_reg = a;
                        8'h18: st_reg = a;
                        8'h1E: i_reg = i_reg + a;
                        8'h29: i_reg = 16'(a * GLYPH_HEIGHT);
                        8'h33:
                        begin
                            ram[12'(i_reg)] = 8'(a / 100);
                            ram[12'(i_reg + 1)] = 8'((a / 10) % 10);
                            ram[12'(i_reg + 2)] = 8'(a % 10);
                        end
                        8'h55:
                            for (int k = 0; k <= x; k++)
                                ram[12'(i_reg + k)] = v_reg[k];
                        8'h65:
                            for (int k = 0; k <= x; k++)
                                v_reg[k] = ram[12'(i_reg + k)];
                        default: ;
                    endcase
                default: ;
            endcase
        r.pc = pc_reg; r.idx = i_reg; r.vf = v_reg[15];
        r.dt = dt_reg; r.st = st_reg;
        pending_views.push_back(r);
    endtask

    task automatic send_beat(input logic act, input logic [15:0] op,
                             input logic [11:0] la = '0, input logic [7:0] ld = '0,
                             input logic [15:0] keys = '0, input logic [3:0] key = '0,
                             input logic [7:0] rnd = '0);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act; opcode <= op; load_address <= la; load_data <= ld;
        keys_down <= keys; wait_key <= key; random_value <= rnd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        execute_model(act, op, la, ld, keys, key, rnd);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_beat(ACT_EXEC, OP_RET);
        send_beat(ACT_LOAD, 16'h0, 12'hFFF, 8'hFF);
        send_beat(ACT_LOAD, 16'h0, 12'h000, 8'h00);
        send_beat(ACT_EXEC, 16'h60FF);
        send_beat(ACT_EXEC, 16'h6101);
        send_beat(ACT_EXEC, 16'h8014);
        send_beat(ACT_EXEC, 16'h8F15);
        send_beat(ACT_EXEC, 16'h6F81);
        send_beat(ACT_EXEC, 16'h8FFE);
        send_beat(ACT_EXEC, 16'h8F16);
        send_beat(ACT_EXEC, 16'h8107);
        send_beat(ACT_EXEC, OP_CLS);
        send_beat(ACT_EXEC, 16'hD01F);
        send_beat(ACT_EXEC, 16'hC0FF, '0, '0, '0, '0, 8'hFF);
        send_beat(ACT_EXEC, 16'hC2FF, '0, '0, '0, '0, 8'hFE);
        send_beat(ACT_EXEC, 16'hE29E, '0, '0, 16'hFFFF);
        send_beat(ACT_EXEC, 16'hE0A1, '0, '0, 16'h0001);
        send_beat(ACT_EXEC, 16'hF20A, '0, '0, '0, 4'hF);
        send_beat(ACT_EXEC, 16'hAFFE);
        send_beat(ACT_EXEC, 16'hF233);
        send_beat(ACT_EXEC, 16'hFF55);
        send_beat(ACT_EXEC, 16'hFF65);
        send_beat(ACT_EXEC, 16'hF01E);
        send_beat(ACT_EXEC, 16'hBFFF);
        send_beat(ACT_EXEC, 16'h5000);
    endtask

    task automatic test_stack_limits();
        for (int k = 0; k < 17; k++)
            send_beat(ACT_EXEC, 16'h2000 | 16'($urandom_range(0, 4095)));
        drain();
        for (int k = 0; k < 17; k++)
            send_beat(ACT_EXEC, OP_RET);
    endtask

    task automatic test_random(input int count);
        logic [15:0] op;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 19);
            op = 16'($urandom);
            if (pick == 0)
                op = OP_CLS;
            else if (pick == 1)
                op = (sp == 0) ? OP_CLS : OP_RET;
            else if (pick < 5)
                op = {4'hF, op[11:8], 8'h07 + 8'($urandom_range(0, 0))};
            if (pick >= 2 && pick < 5)
                case ($urandom_range(0, 8))
                    0: op[7:0] = 8'h07;
                    1: op[7:0] = 8'h0A;
                    2: op[7:0] = 8'h15;
                    3: op[7:0] = 8'h18;
                    4: op[7:0] = 8'h1E;
                    5: op[7:0] = 8'h29;
                    6: op[7:0] = 8'h33;
                    7: op[7:0] = 8'h55;
                    default: op[7:0] = 8'h65;
                endcase
            else if (pick == 5)
                op = {4'h8, op[11:4], 4'($urandom_range(0, 1) ? 4'hE : op[2:0])};
            else if (pick == 6)
                op = {4'hE, op[11:8], $urandom_range(0, 1) ? KK_SKP : KK_SKNP};
            if (op == OP_RET && sp == 0)
                op = OP_CLS;
            if ($urandom_range(0, 24) == 0)
                send_beat(ACT_LOAD, op, 12'($urandom), 8'($urandom));
            else
                send_beat(ACT_EXEC, op, 12'($urandom), 8'($urandom), 16'($urandom),
                          4'($urandom), 8'($urandom));
            if (k == count / 2)
                drain();
        end
    endtask

    initial
    begin
        machine_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_stack_limits();
        test_random(1850);
        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
